/* rtl/core/pbb_pkg.sv */
// Shared constants, types and pixel helper functions for the blend blit block.
// Depends on nothing; the top level, sequencer, pipeline and testbench files import it, the port checker does not.
`timescale 1ns / 1ps

package pbb_pkg;

	localparam int FB_WIDTH = 256;
	localparam int FB_HEIGHT = 256;
	localparam int FB_AW = $clog2(FB_WIDTH * FB_HEIGHT);
	localparam int FB_DEPTH = FB_WIDTH * FB_HEIGHT;

	// Position before the framebuffer bounds check: offset plus rectangle corner.
	localparam int POS_W = 9;

	localparam logic [31:0] SPREAD_MASK = 32'b00000111111000001111100000011111;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

	localparam logic FMT_565 = 1'b0;
	localparam logic FMT_RGBA = 1'b1;

	// One accepted byte as seen by the read-modify-write pipeline.
	typedef struct packed {
		logic [7:0] data;
		logic mode;
		logic ign;
		logic last;
		logic on;
		logic fin;
		logic [7:0] col;
		logic [7:0] row;
		logic [FB_AW-1:0] addr;
		logic [15:0] fg;
	} pbb_item_t;

	function automatic logic [15:0] rgb888_to_565(input logic [23:0] c);
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

	// Green moves to the top half so each channel has headroom for the lerp.
	function automatic logic [31:0] spread565(input logic [15:0] c);
		return {c, c} & SPREAD_MASK;
	endfunction

	function automatic logic [15:0] fold565(input logic [31:0] r);
		return r[31:16] | r[15:0];
	endfunction

	function automatic logic [5:0] alpha_scale(input logic [7:0] a8);
		logic [8:0] t;
		t = {1'b0, a8} + 9'd4;
		return t[8:3];
	endfunction

endpackage

/* rtl/core/pixel_stream_blend_blit.sv */
// An accepted byte passes through stage 1, stage 2 and the result register to the output.
// Throughput: one byte per cycle while neither the clearing pass nor a held result stalls
// the input; the framebuffer has one write and one read port and a read-modify-write
// round trip of two stages covered by forwarding.
// Reset: all control clears at once; then a clearing pass zeroes the 65536-word
// framebuffer, one word per cycle, holding byte_stall high until the last word is cleared.
`timescale 1ns / 1ps

module pixel_stream_blend_blit
	import pbb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic byte_valid,
	output logic byte_stall,
	input  logic [7:0] data_byte,
	output logic pixel_valid,
	input  logic pixel_stall,
	output logic pixel_written,
	output logic [7:0] pixel_col,
	output logic [7:0] pixel_row,
	output logic [15:0] pixel_value,
	output logic off_screen,
	output logic finished
);

	logic adv;
	logic take;
	logic clearing;
	pbb_item_t item;

	// The whole pipeline moves together unless the result register is held.
	assign adv = !pixel_valid || !pixel_stall;
	assign byte_stall = clearing || !adv;
	assign take = byte_valid && !byte_stall;
	// Configuration writes are taken at any time, including during the clearing pass.
	assign cfg_ready = 1'b1;

	pbb_cfg_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.take(take),
		.data_byte(data_byte),
		.item(item)
	);

	pbb_rmw_pipe u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.take(take),
		.item(item),
		.clearing(clearing),
		.out_valid(pixel_valid),
		.out_written(pixel_written),
		.out_col(pixel_col),
		.out_row(pixel_row),
		.out_value(pixel_value),
		.out_off(off_screen),
		.out_fin(finished)
	);

endmodule

/* rtl/core/pbb_cfg_seq.sv */
// Configuration registers and the byte sequencer that walks the rectangle.
// Depends on pbb_pkg; produces one item description per accepted beat.
`timescale 1ns / 1ps

module pbb_cfg_seq
	import pbb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic take,
	input  logic [7:0] data_byte,
	output pbb_item_t item
);

	logic fmt_q;
	logic [7:0] left_q;
	logic [7:0] top_q;
	logic [8:0] width_q;
	logic [8:0] height_q;

	logic [1:0] phase_q;
	logic [7:0] col_off_q;
	logic [7:0] row_off_q;
	logic done_q;
	logic [23:0] accum_q;

	logic [7:0] w_m1;
	logic [7:0] h_m1;
	logic [1:0] bpp_m1;
	logic last;
	logic row_end;
	logic [POS_W-1:0] col;
	logic [POS_W-1:0] row;
	logic on;
	logic cfg_hit;

	// Width and height of zero act as one, anything above 256 as 256.
	always_comb begin
		if (width_q == 9'd0) begin
			w_m1 = 8'd0;
		end else if (width_q > 9'd256) begin
			w_m1 = 8'd255;
		end else begin
			w_m1 = 8'(width_q - 9'd1);
		end
		if (height_q == 9'd0) begin
			h_m1 = 8'd0;
		end else if (height_q > 9'd256) begin
			h_m1 = 8'd255;
		end else begin
			h_m1 = 8'(height_q - 9'd1);
		end
	end

	assign bpp_m1 = (fmt_q == FMT_RGBA) ? 2'd3 : 2'd1;
	assign last = (phase_q == bpp_m1);
	assign row_end = (col_off_q == w_m1);
	assign col = {1'b0, col_off_q} + {1'b0, left_q};
	assign row = {1'b0, row_off_q} + {1'b0, top_q};
	assign on = (32'(col) < FB_WIDTH) && (32'(row) < FB_HEIGHT);

	always_comb begin
		item.data = data_byte;
		item.mode = fmt_q;
		item.ign = done_q;
		item.last = last;
		item.on = on;
		item.fin = last && row_end && (row_off_q == h_m1);
		item.col = col[7:0];
		item.row = row[7:0];
		item.addr = FB_AW'(32'(row) * FB_WIDTH + 32'(col));
		item.fg = rgb888_to_565(accum_q);
	end

	always_comb begin
		unique case (cfg_index) inside
			REG_FORMAT, REG_LEFT, REG_TOP, REG_WIDTH, REG_HEIGHT: cfg_hit = cfg_valid;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_565;
			left_q <= 8'd0;
			top_q <= 8'd0;
			width_q <= 9'd1;
			height_q <= 9'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FORMAT: fmt_q <= cfg_data[0];
				REG_LEFT: left_q <= cfg_data[7:0];
				REG_TOP: top_q <= cfg_data[7:0];
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			col_off_q <= 8'd0;
			row_off_q <= 8'd0;
			done_q <= 1'b0;
			accum_q <= 24'd0;
		end else if (cfg_hit) begin
			phase_q <= 2'd0;
			col_off_q <= 8'd0;
			row_off_q <= 8'd0;
			done_q <= 1'b0;
			accum_q <= 24'd0;
		end else if (take && !done_q) begin
			done_q <= item.fin;
			if (fmt_q == FMT_RGBA) begin
				accum_q <= {accum_q[15:0], data_byte};
			end
			if (last) begin
				phase_q <= 2'd0;
				if (row_end) begin
					col_off_q <= 8'd0;
					row_off_q <= row_off_q + 8'd1;
				end else begin
					col_off_q <= col_off_q + 8'd1;
				end
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

endmodule

/* rtl/core/pbb_rmw_pipe.sv */
// Framebuffer memory with its clearing pass and the read-modify-write pipeline.
// Depends on pbb_pkg; takes item descriptions from pbb_cfg_seq.
`timescale 1ns / 1ps

module pbb_rmw_pipe
	import pbb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic take,
	input  pbb_item_t item,
	output logic clearing,
	output logic out_valid,
	output logic out_written,
	output logic [7:0] out_col,
	output logic [7:0] out_row,
	output logic [15:0] out_value,
	output logic out_off,
	output logic out_fin
);

	logic [15:0] mem [FB_DEPTH];
	logic [15:0] rd_q;

	logic clr_q;
	logic [FB_AW-1:0] clr_addr_q;

	// Stage 1: memory data arrives, old pixel resolved, 565 update or blend product.
	logic v_s1;
	pbb_item_t it_s1;
	logic wr_s1;
	logic [15:0] old_s1;
	logic [31:0] bsp_s1;
	logic [31:0] diff_s1;
	logic [5:0] alpha_s1;

	// Stage 2: blend sum, write back, result formed.
	logic v_s2;
	logic wr_s2;
	logic mode_s2;
	logic [FB_AW-1:0] addr_s2;
	logic [15:0] val565_s2;
	logic [31:0] prod_s2;
	logic [31:0] bsp_s2;
	logic rep_s2;
	logic on_s2;
	logic fin_s2;
	logic [7:0] col_s2;
	logic [7:0] row_s2;
	logic [31:0] sum_s2;
	logic [15:0] new_s2;

	// Write that lands at the same edge as a read, which returns the old word.
	logic fwd_v_q;
	logic [FB_AW-1:0] fwd_addr_q;
	logic [15:0] fwd_data_q;

	logic out_valid_q;
	logic out_written_q;
	logic [7:0] out_col_q;
	logic [7:0] out_row_q;
	logic [15:0] out_value_q;
	logic out_off_q;
	logic out_fin_q;

	assign clearing = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + FB_AW'(1);
			if (&clr_addr_q) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= 16'd0;
		end else if (adv && v_s2 && wr_s2) begin
			mem[addr_s2] <= new_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q <= mem[item.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			fwd_v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			fwd_v_q <= v_s2 && wr_s2;
		end
	end

	// Only a 565 beat can hit the word that the next beat modifies: its value is
	// final in stage 2. RGBA writes are four beats apart and never share a pixel.
	always_comb begin
		if (v_s2 && wr_s2 && (mode_s2 == FMT_565) && (addr_s2 == it_s1.addr)) begin
			old_s1 = val565_s2;
		end else if (fwd_v_q && (fwd_addr_q == it_s1.addr)) begin
			old_s1 = fwd_data_q;
		end else begin
			old_s1 = rd_q;
		end
	end

	assign wr_s1 = !it_s1.ign && it_s1.on && ((it_s1.mode == FMT_565) || it_s1.last);
	assign bsp_s1 = spread565(old_s1);
	assign diff_s1 = spread565(it_s1.fg) - bsp_s1;
	assign alpha_s1 = alpha_scale(it_s1.data);

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= item;
			wr_s2 <= wr_s1;
			mode_s2 <= it_s1.mode;
			addr_s2 <= it_s1.addr;
			val565_s2 <= {old_s1[7:0], it_s1.data};
			prod_s2 <= diff_s1 * 32'(alpha_s1);
			bsp_s2 <= bsp_s1;
			rep_s2 <= !it_s1.ign && it_s1.last;
			on_s2 <= it_s1.on;
			fin_s2 <= it_s1.ign || it_s1.fin;
			col_s2 <= it_s1.col;
			row_s2 <= it_s1.row;
			fwd_addr_q <= addr_s2;
			fwd_data_q <= new_s2;
		end
	end

	assign sum_s2 = ((prod_s2 >> 5) + bsp_s2) & SPREAD_MASK;
	assign new_s2 = (mode_s2 == FMT_RGBA) ? fold565(sum_s2) : val565_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_written_q <= rep_s2 && on_s2;
			out_off_q <= rep_s2 && !on_s2;
			out_col_q <= rep_s2 ? col_s2 : 8'd0;
			out_row_q <= rep_s2 ? row_s2 : 8'd0;
			out_value_q <= (rep_s2 && on_s2) ? new_s2 : 16'd0;
			out_fin_q <= fin_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_written = out_written_q;
	assign out_col = out_col_q;
	assign out_row = out_row_q;
	assign out_value = out_value_q;
	assign out_off = out_off_q;
	assign out_fin = out_fin_q;

endmodule

/* rtl/core/pbb_checker.sv */
// Port-level checks on the blend blit result channel, with the bind to the top level.
// Depends only on the port list of pixel_stream_blend_blit.
`timescale 1ns / 1ps

module pbb_port_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic pixel_valid,
	input  logic pixel_stall,
	input  logic pixel_written,
	input  logic [7:0] pixel_col,
	input  logic [7:0] pixel_row,
	input  logic [15:0] pixel_value,
	input  logic off_screen,
	input  logic finished
);

	// A completed pixel is either stored or dropped, never both.
	a_written_xor_off: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> !(pixel_written && off_screen))
		else $error("pixel beat both written and off screen");

	// Only a stored pixel carries a value.
	a_value_only_when_written: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_written |-> pixel_value == 16'd0)
		else $error("pixel value on a beat that stored nothing");

	// A beat that completes no pixel reports no position.
	a_no_pos_without_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_written && !off_screen
			|-> pixel_col == 8'd0 && pixel_row == 8'd0)
		else $error("position reported on a beat without a pixel");

	a_stalled_beat_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_value)
			&& $stable(pixel_written) && $stable(finished))
		else $error("stalled result beat changed");

endmodule

bind pixel_stream_blend_blit pbb_port_checker u_chk (.*);

/* tb/pbb_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the blend blit block. It mirrors the registers and the framebuffer,
// predicts one result beat per accepted byte and compares the output channel with it.
// Depends on pbb_pkg for sizes, register indexes, formats and the spread mask.

module pbb_checker
	import pbb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic byte_valid,
	input  logic byte_stall,
	input  logic [7:0] data_byte,
	input  logic pixel_valid,
	input  logic pixel_stall,
	input  logic pixel_written,
	input  logic [7:0] pixel_col,
	input  logic [7:0] pixel_row,
	input  logic [15:0] pixel_value,
	input  logic off_screen,
	input  logic finished,
	output int fail_count,
	output int outstanding
);

	typedef struct packed {
		logic written;
		logic [7:0] col;
		logic [7:0] row;
		logic [15:0] value;
		logic off;
		logic fin;
	} pixel_beat_t;

	logic [15:0] shadow_fb [FB_DEPTH];
	logic fmt_rgba;
	logic [7:0] left_q;
	logic [7:0] top_q;
	logic [8:0] width_q;
	logic [8:0] height_q;
	logic [18:0] bytes_seen;
	logic [23:0] color_acc;
	logic rect_done;
	pixel_beat_t expected_pixels [$];

	function automatic int unsigned clamp_dim(input logic [8:0] v);
		if (v == 9'd0)
			return 1;
		if (v > 9'd256)
			return 256;
		return v;
	endfunction

	// Both colors are spread so green sits in the top half; the lerp wraps at 32 bits.
	function automatic logic [15:0] blend_over(input logic [15:0] fg, input logic [15:0] bg,
			input logic [7:0] alpha);
		logic [31:0] fs;
		logic [31:0] bs;
		logic [31:0] mix;
		logic [31:0] a32;
		a32 = (32'(alpha) + 32'd4) >> 3;
		fs = {fg, fg} & SPREAD_MASK;
		bs = {bg, bg} & SPREAD_MASK;
		mix = (fs - bs) * a32;
		mix = ((mix >> 5) + bs) & SPREAD_MASK;
		return mix[31:16] | mix[15:0];
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_FORMAT: fmt_rgba = val[0];
			REG_LEFT: left_q = val[7:0];
			REG_TOP: top_q = val[7:0];
			REG_WIDTH: width_q = val[8:0];
			REG_HEIGHT: height_q = val[8:0];
			default: return;
		endcase
		bytes_seen = '0;
		color_acc = '0;
		rect_done = 1'b0;
	endtask

	task automatic blit_byte(input logic [7:0] b, output pixel_beat_t res);
		int unsigned w;
		int unsigned h;
		int unsigned bpp;
		int unsigned total;
		int unsigned pix;
		int unsigned col;
		int unsigned row;
		int unsigned addr;
		logic on;
		logic last;
		res = '0;
		if (rect_done) begin
			res.fin = 1'b1;
			return;
		end
		w = clamp_dim(width_q);
		h = clamp_dim(height_q);
		bpp = fmt_rgba ? 4 : 2;
		total = bpp * w * h;
		pix = bytes_seen / bpp;
		col = pix % w + left_q;
		row = pix / w + top_q;
		on = (col < FB_WIDTH) && (row < FB_HEIGHT);
		last = (bytes_seen % bpp) == bpp - 1;
		addr = row * FB_WIDTH + col;
		if (fmt_rgba == FMT_565) begin
			// Every byte shifts into the target pixel, even the first of the pair.
			if (on) begin
				shadow_fb[addr] = {shadow_fb[addr][7:0], b};
				res.value = shadow_fb[addr];
			end
		end else begin
			if (last && on) begin
				shadow_fb[addr] = blend_over({color_acc[23:19], color_acc[15:10], color_acc[7:3]},
					shadow_fb[addr], b);
				res.value = shadow_fb[addr];
			end
			color_acc = {color_acc[15:0], b};
		end
		if (last) begin
			res.written = on;
			res.off = !on;
			res.col = 8'(col);
			res.row = 8'(row);
			if (!on)
				res.value = '0;
		end else begin
			res.value = '0;
		end
		bytes_seen = bytes_seen + 19'd1;
		if (bytes_seen >= total)
			rect_done = 1'b1;
		res.fin = rect_done;
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		pixel_beat_t want;
		if (!arst_n) begin
			foreach (shadow_fb[i])
				shadow_fb[i] = '0;
			fmt_rgba = FMT_565;
			left_q = '0;
			top_q = '0;
			width_q = 9'd1;
			height_q = 9'd1;
			bytes_seen = '0;
			color_acc = '0;
			rect_done = 1'b0;
			expected_pixels.delete();
			fail_count = 0;
		end else begin
			// The result side goes first so a beat never meets its own prediction.
			if (pixel_valid && !pixel_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual col %0h row %0h value %0h",
						$time, pixel_col, pixel_row, pixel_value);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel_written", want.written, pixel_written);
					check_field("pixel_col", want.col, pixel_col);
					check_field("pixel_row", want.row, pixel_row);
					check_field("pixel_value", want.value, pixel_value);
					check_field("off_screen", want.off, off_screen);
					check_field("finished", want.fin, finished);
				end
			end
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (byte_valid && !byte_stall) begin
				blit_byte(data_byte, want);
				expected_pixels.push_back(want);
			end
		end
		outstanding = expected_pixels.size();
	end

endmodule

/* tb/tb_pixel_stream_blend_blit.sv */
`timescale 1ns / 1ps
// Top of the blend blit testbench: clock, reset, register writes and byte stimulus.
// Depends on pbb_pkg, the pixel_stream_blend_blit block and the pbb_checker scoreboard.

module tb_pixel_stream_blend_blit;
	import pbb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	logic [7:0] data_byte = '0;
	logic pixel_valid;
	logic pixel_stall = 1'b0;
	logic pixel_written;
	logic [7:0] pixel_col;
	logic [7:0] pixel_row;
	logic [15:0] pixel_value;
	logic off_screen;
	logic finished;
	int fail_count;
	int outstanding;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	pixel_stream_blend_blit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_written(pixel_written),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.pixel_value(pixel_value),
		.off_screen(off_screen),
		.finished(finished)
	);

	pbb_checker u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_written(pixel_written),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.pixel_value(pixel_value),
		.off_screen(off_screen),
		.finished(finished),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	always @(negedge clk) begin
		pixel_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Starts and ends at a falling edge; the valid is left high for the caller.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] fmt, input logic [CFG_DATA_W-1:0] left,
			input logic [CFG_DATA_W-1:0] top, input logic [CFG_DATA_W-1:0] width,
			input logic [CFG_DATA_W-1:0] height);
		write_reg(REG_FORMAT, fmt);
		write_reg(REG_LEFT, left);
		write_reg(REG_TOP, top);
		write_reg(REG_WIDTH, width);
		write_reg(REG_HEIGHT, height);
		cfg_valid <= 1'b0;
	endtask

	// Starts and ends at a falling edge, with the valid still high after the beat.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		do
			@(posedge clk);
		while (byte_stall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		byte_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_directed();
		// Reset geometry is one 565 pixel at the origin; the third byte comes after finish.
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'hAB);
		drain_results();
		// Zero size falls back to one pixel: white at half alpha over the stored pixel.
		configure(9'(FMT_RGBA), 9'd0, 9'd0, 9'd0, 9'd0);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h00);
		drain_results();
		// Bottom-right corner: full alpha, zero alpha, then a pixel past the right edge.
		configure(9'(FMT_RGBA), 9'd254, 9'd255, 9'd3, 9'd1);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h7F);
		drain_results();
		// Oversize width is cut to 256; a write to an unused index must not restart the row.
		configure(9'(FMT_565), 9'd255, 9'd255, 9'd300, 9'd1);
		send_byte(8'hFF);
		send_byte(8'hFF);
		drain_results();
		write_reg(REG_UNUSED, 9'h1FF);
		cfg_valid <= 1'b0;
		send_byte(8'h00);
		send_byte(8'h01);
		drain_results();
	endtask

	task automatic run_random(input int live_target);
		int live;
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int n;
		int pause_at;
		logic [CFG_DATA_W-1:0] fmt_d;
		logic [CFG_DATA_W-1:0] left_d;
		logic [CFG_DATA_W-1:0] top_d;
		logic [CFG_DATA_W-1:0] width_d;
		logic [CFG_DATA_W-1:0] height_d;
		logic [7:0] b;
		live = 0;
		while (live < live_target) begin
			drain_results();
			fmt_d = 9'($urandom_range(3));
			case ($urandom_range(3))
				0: left_d = 9'($urandom_range(255, 248));
				1: left_d = '0;
				default: left_d = 9'($urandom_range(511));
			endcase
			case ($urandom_range(3))
				0: top_d = 9'($urandom_range(255, 248));
				1: top_d = '0;
				default: top_d = 9'($urandom_range(511));
			endcase
			case ($urandom_range(15))
				0: width_d = '0;
				1: width_d = 9'($urandom_range(511, 257));
				2: width_d = 9'd256;
				default: width_d = 9'($urandom_range(6, 1));
			endcase
			case ($urandom_range(15))
				0: height_d = '0;
				1: height_d = 9'($urandom_range(511, 257));
				2: height_d = 9'd256;
				default: height_d = 9'($urandom_range(6, 1));
			endcase
			configure(fmt_d, left_d, top_d, width_d, height_d);
			w = (width_d == 0) ? 1 : ((width_d > 256) ? 256 : width_d);
			h = (height_d == 0) ? 1 : ((height_d > 256) ? 256 : height_d);
			total = (fmt_d[0] ? 4 : 2) * w * h;
			// Small rectangles are run to the end and up to three bytes past it; big ones only in part.
			if (total <= 160)
				n = total + $urandom_range(3);
			else
				n = $urandom_range(96, 24);
			pause_at = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : -1;
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(7))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom());
				endcase
				send_byte(b);
				if (i == pause_at)
					drain_results();
			end
			live += (n < total) ? n : total;
		end
	endtask

	initial begin
		wait (arst_n);
		@(negedge clk);
		send_idle_pct = 31;
		recv_idle_pct = 61;
		run_directed();
		run_random(250);
		send_idle_pct = 61;
		recv_idle_pct = 31;
		run_random(250);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(230);
		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
